// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at the clock after the antecedent.
`define NCF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ncf checker: property failed");

// The consequent must hold at the same clock as the antecedent.
`define NCF_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ncf checker: property failed");

`endif

// ===== rtl/core/ncf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, controller states and control structs of the cohesion force block.
package ncf_pkg;

    localparam int NBR_DEPTH = 64;
    localparam int NBR_AW    = 6;
    localparam int FRAC      = 16;
    localparam int DIV_W     = 50;
    localparam int DIV_CW    = 6;

    localparam logic [2:0] CFG_ACTIVE   = 3'd0;
    localparam logic [2:0] CFG_MIN_DIST = 3'd1;
    localparam logic [2:0] CFG_MAX_DIST = 3'd2;
    localparam logic [2:0] CFG_AMOUNT   = 3'd3;
    localparam logic [2:0] CFG_NBR_USE  = 3'd4;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [27:0] {
        S_IDLE = 28'h0000001,
        S_INIT = 28'h0000002,
        S_MX2  = 28'h0000004,
        S_LIM  = 28'h0000008,
        S_RD   = 28'h0000010,
        S_DIFF = 28'h0000020,
        S_SQX  = 28'h0000040,
        S_SQY  = 28'h0000080,
        S_SQZ  = 28'h0000100,
        S_ACC  = 28'h0000200,
        S_CHK  = 28'h0000400,
        S_AV_S = 28'h0000800,
        S_AV_W = 28'h0001000,
        S_AQX  = 28'h0002000,
        S_AQY  = 28'h0004000,
        S_AQZ  = 28'h0008000,
        S_AQS  = 28'h0010000,
        S_SQ_W = 28'h0020000,
        S_LEN  = 28'h0040000,
        S_SC_S = 28'h0080000,
        S_SC_W = 28'h0100000,
        S_U_S  = 28'h0200000,
        S_U_W  = 28'h0400000,
        S_G_M  = 28'h0800000,
        S_G_T  = 28'h1000000,
        S_F_M  = 28'h2000000,
        S_F_T  = 28'h4000000,
        S_OUT  = 28'h8000000
    } t_state;

    typedef struct packed {
        t_state step;
        logic   take;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic n_zero;
        logic walk_last;
        logic cnt_zero;
        logic div_done;
        logic sqrt_done;
        logic len_zero;
        logic scale_div;
        logic comp_last;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/neighbor_cohesion_force.sv =====
`timescale 1ns / 1ps
// Top level of the neighbor cohesion force block.
//
//  channel   direction  handshake                 word
//  input     in         i_in_valid / o_in_stall   op, index, pos_x, pos_y, pos_z
//  result    out        o_out_valid / i_out_stall part_id, force_x, force_y, force_z
//  config    in         i_cfg_we (no handshake)   i_cfg_index, i_cfg_data
//
// A load word is taken in idle and writes one slot of the 64-entry neighbor memory.
// A query walks N neighbors, each in the steps read, difference, three squarings and
// accumulate, then runs up to seven divisions on the shared bit-serial divider and
// a bit-serial square root.
// Reset is synchronous, active low, and spares the neighbor memory; a finished force
// waits in the output register, so the next word is accepted while the result stalls.
module neighbor_cohesion_force (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [5:0]         i_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [5:0]         o_part_id,
    output logic signed [31:0] o_force_x,
    output logic signed [31:0] o_force_y,
    output logic signed [31:0] o_force_z
);

    // The controller only issues step codes and the take strobe; all arithmetic lives in the datapath.
    ncf_pkg::t_cmd  w_cmd;
    ncf_pkg::t_stat w_stat;

    ncf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath writes loads straight from the ports when the controller takes a
    // word, and latches the query position for the walk.
    ncf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_op        (i_op),
        .i_index     (i_index),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pos_z     (i_pos_z),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_part_id   (o_part_id),
        .o_force_x   (o_force_x),
        .o_force_y   (o_force_y),
        .o_force_z   (o_force_z)
    );

endmodule

// ===== rtl/core/ncf_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module ncf_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ncf_pkg::DIV_W-1:0] i_dividend,
    input  logic [31:0]              i_divisor,
    output logic [ncf_pkg::DIV_W-1:0] o_quotient,
    output logic                     o_done
);

    logic                        r_busy;
    logic                        r_done;
    logic [ncf_pkg::DIV_CW-1:0]  r_cnt;
    logic [31:0]                 r_rem;
    logic [31:0]                 r_div;
    logic [ncf_pkg::DIV_W-1:0]   r_quo;
    logic [32:0]                 w_rem_sh;
    logic [33:0]                 w_diff;

    assign w_rem_sh = {r_rem, r_quo[ncf_pkg::DIV_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ncf_pkg::DIV_CW'(ncf_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[33]) begin
                r_rem <= w_diff[31:0];
                r_quo <= {r_quo[ncf_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[31:0];
                r_quo <= {r_quo[ncf_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== rtl/core/ncf_sqrt.sv =====
`timescale 1ns / 1ps
// Integer square root of a 64-bit value, one root bit per cycle.
module ncf_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic [31:0] o_root,
    output logic        o_done
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [32:0] r_rem;
    logic [31:0] r_root;
    logic [34:0] w_rem_sh;
    logic [34:0] w_trial;
    logic [35:0] w_diff;

    assign w_rem_sh = {r_rem, r_rad[63:62]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_diff   = {1'b0, w_rem_sh} - {1'b0, w_trial};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[61:0], 2'b00};
            if (!w_diff[35]) begin
                r_rem  <= w_diff[32:0];
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[32:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

// ===== rtl/core/ncf_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration, neighbor memory, multiplier, divider, root and output register.
module ncf_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ncf_pkg::t_cmd         i_cmd,
    output ncf_pkg::t_stat        o_stat,
    input  logic                  i_op,
    input  logic [5:0]            i_index,
    input  logic signed [31:0]    i_pos_x,
    input  logic signed [31:0]    i_pos_y,
    input  logic signed [31:0]    i_pos_z,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [5:0]            o_part_id,
    output logic signed [31:0]    o_force_x,
    output logic signed [31:0]    o_force_y,
    output logic signed [31:0]    o_force_z
);

    function automatic logic signed [67:0] f_trunc(input logic signed [67:0] p);
        logic signed [67:0] bias;
        bias = p[67] ? ((68'sd1 <<< ncf_pkg::FRAC) - 68'sd1) : 68'sd0;
        return (p + bias) >>> ncf_pkg::FRAC;
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [67:0] p);
        logic [31:0] res;
        if (p > 68'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (p < -68'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = p[31:0];
        end
        return res;
    endfunction

    // Configuration registers.
    logic               r_active;
    logic [30:0]        r_min;
    logic [30:0]        r_max;
    logic signed [31:0] r_amount;
    logic [6:0]         r_niu;

    // Query and walk state.
    logic signed [31:0] r_px, r_py, r_pz;
    logic [5:0]         r_id;
    logic [95:0]        r_mem [ncf_pkg::NBR_DEPTH];
    logic [95:0]        r_rdata;
    logic [6:0]         r_k;
    logic signed [32:0] r_dx, r_dy, r_dz;
    logic               r_within;
    logic signed [67:0] r_prod;
    logic [63:0]        r_sq;
    logic [61:0]        r_mn2, r_mx2;
    logic signed [37:0] r_sx, r_sy, r_sz;
    logic [6:0]         r_cnt;

    // Force computation.
    logic [1:0]         r_j;
    logic signed [31:0] r_avg [3];
    logic [31:0]        r_len;
    logic signed [31:0] r_scale;
    logic signed [17:0] r_u;
    logic signed [32:0] r_g;
    logic signed [31:0] r_f [3];

    // Output register.
    logic               r_ov;
    logic [5:0]         r_o_id;
    logic signed [31:0] r_o_fx, r_o_fy, r_o_fz;

    logic [6:0]                 w_n_use;
    logic signed [32:0]         w_dx, w_dy, w_dz;
    logic [32:0]                w_ax, w_ay, w_az;
    logic [63:0]                w_sqt;
    logic signed [33:0]         w_ma, w_mb;
    logic signed [37:0]         w_sj;
    logic [37:0]                w_smag;
    logic [31:0]                w_amag;
    logic signed [32:0]         w_num;
    logic [31:0]                w_nmag;
    logic [31:0]                w_den;
    logic                       w_div_start;
    logic [ncf_pkg::DIV_W-1:0]  w_dividend;
    logic [31:0]                w_divisor;
    logic [ncf_pkg::DIV_W-1:0]  w_quo;
    logic                       w_div_done;
    logic [31:0]                w_root;
    logic                       w_sqrt_done;
    logic                       w_out_free;
    logic signed [67:0]         w_ptr;

    assign w_n_use = (r_niu > 7'(ncf_pkg::NBR_DEPTH)) ? 7'(ncf_pkg::NBR_DEPTH) : r_niu;

    assign w_dx = {r_rdata[95], r_rdata[95:64]} - {r_px[31], r_px};
    assign w_dy = {r_rdata[63], r_rdata[63:32]} - {r_py[31], r_py};
    assign w_dz = {r_rdata[31], r_rdata[31:0]}  - {r_pz[31], r_pz};
    assign w_ax = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_ay = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
    assign w_az = w_dz[32] ? 33'(-w_dz) : 33'(w_dz);

    assign w_sqt = r_sq + r_prod[63:0];

    always_comb begin
        case (r_j)
            2'd0:    w_sj = r_sx;
            2'd1:    w_sj = r_sy;
            default: w_sj = r_sz;
        endcase
    end
    assign w_smag = w_sj[37] ? 38'(-w_sj) : 38'(w_sj);
    assign w_amag = r_avg[r_j][31] ? 32'(-r_avg[r_j]) : 32'(r_avg[r_j]);
    assign w_num  = {1'b0, r_len} - {2'b00, r_min};
    assign w_nmag = w_num[32] ? 32'(-w_num) : w_num[31:0];
    assign w_den  = {1'b0, r_max} - {1'b0, r_min};
    assign w_ptr  = f_trunc(r_prod);

    // Multiplier operand selection.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.step)
            ncf_pkg::S_INIT: begin
                w_ma = {3'b000, r_min};
                w_mb = {3'b000, r_min};
            end
            ncf_pkg::S_MX2: begin
                w_ma = {3'b000, r_max};
                w_mb = {3'b000, r_max};
            end
            ncf_pkg::S_SQX: begin
                w_ma = {r_dx[32], r_dx};
                w_mb = {r_dx[32], r_dx};
            end
            ncf_pkg::S_SQY: begin
                w_ma = {r_dy[32], r_dy};
                w_mb = {r_dy[32], r_dy};
            end
            ncf_pkg::S_SQZ: begin
                w_ma = {r_dz[32], r_dz};
                w_mb = {r_dz[32], r_dz};
            end
            ncf_pkg::S_AQX: begin
                w_ma = {{2{r_avg[0][31]}}, r_avg[0]};
                w_mb = {{2{r_avg[0][31]}}, r_avg[0]};
            end
            ncf_pkg::S_AQY: begin
                w_ma = {{2{r_avg[1][31]}}, r_avg[1]};
                w_mb = {{2{r_avg[1][31]}}, r_avg[1]};
            end
            ncf_pkg::S_AQZ: begin
                w_ma = {{2{r_avg[2][31]}}, r_avg[2]};
                w_mb = {{2{r_avg[2][31]}}, r_avg[2]};
            end
            ncf_pkg::S_G_M: begin
                w_ma = {{16{r_u[17]}}, r_u};
                w_mb = {{2{r_scale[31]}}, r_scale};
            end
            ncf_pkg::S_F_M: begin
                w_ma = {r_g[32], r_g};
                w_mb = {{2{r_amount[31]}}, r_amount};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Divider operand selection.
    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = '0;
        w_divisor   = '0;
        unique case (i_cmd.step)
            ncf_pkg::S_AV_S: begin
                w_div_start = 1'b1;
                w_dividend  = ncf_pkg::DIV_W'(w_smag);
                w_divisor   = {25'd0, r_cnt};
            end
            ncf_pkg::S_SC_S: begin
                w_div_start = 1'b1;
                w_dividend  = ncf_pkg::DIV_W'({w_nmag, 16'd0});
                w_divisor   = w_den;
            end
            ncf_pkg::S_U_S: begin
                w_div_start = 1'b1;
                w_dividend  = ncf_pkg::DIV_W'({w_amag, 16'd0});
                w_divisor   = r_len;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    ncf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    ncf_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.step == ncf_pkg::S_AQS),
        .i_radicand (w_sqt),
        .o_root     (w_root),
        .o_done     (w_sqrt_done)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_min    <= '0;
            r_max    <= 31'd655360;
            r_amount <= 32'sd65536;
            r_niu    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ncf_pkg::CFG_ACTIVE:   r_active <= i_cfg_data[0];
                ncf_pkg::CFG_MIN_DIST: r_min    <= i_cfg_data[30:0];
                ncf_pkg::CFG_MAX_DIST: r_max    <= i_cfg_data[30:0];
                ncf_pkg::CFG_AMOUNT:   r_amount <= i_cfg_data;
                ncf_pkg::CFG_NBR_USE:  r_niu    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Neighbor memory, x in the top third of a word, z in the bottom.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_op == ncf_pkg::OP_LOAD
            && {1'b0, i_index} < 7'(ncf_pkg::NBR_DEPTH)) begin
            r_mem[i_index[ncf_pkg::NBR_AW-1:0]] <= {i_pos_x, i_pos_y, i_pos_z};
        end
        r_rdata <= r_mem[r_k[ncf_pkg::NBR_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // Datapath steps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_op == ncf_pkg::OP_QUERY) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_pz <= i_pos_z;
            r_id <= i_index;
        end
        unique case (i_cmd.step)
            ncf_pkg::S_INIT: begin
                r_sx  <= '0;
                r_sy  <= '0;
                r_sz  <= '0;
                r_cnt <= '0;
                r_k   <= '0;
            end
            ncf_pkg::S_MX2: r_mn2 <= r_prod[61:0];
            ncf_pkg::S_LIM: r_mx2 <= r_prod[61:0];
            ncf_pkg::S_DIFF: begin
                r_dx     <= w_dx;
                r_dy     <= w_dy;
                r_dz     <= w_dz;
                r_within <= (w_ax <= {2'b00, r_max}) && (w_ay <= {2'b00, r_max})
                            && (w_az <= {2'b00, r_max});
            end
            ncf_pkg::S_SQY: r_sq <= r_prod[63:0];
            ncf_pkg::S_SQZ: r_sq <= w_sqt;
            ncf_pkg::S_ACC: begin
                if (r_within && w_sqt >= {2'b00, r_mn2} && w_sqt <= {2'b00, r_mx2}) begin
                    r_sx  <= r_sx + {{5{r_dx[32]}}, r_dx};
                    r_sy  <= r_sy + {{5{r_dy[32]}}, r_dy};
                    r_sz  <= r_sz + {{5{r_dz[32]}}, r_dz};
                    r_cnt <= r_cnt + 1'b1;
                end
                r_k <= r_k + 1'b1;
            end
            ncf_pkg::S_CHK: r_j <= '0;
            ncf_pkg::S_AV_W: begin
                if (w_div_done) begin
                    r_avg[r_j] <= w_sj[37] ? -w_quo[31:0] : w_quo[31:0];
                    r_j        <= r_j + 1'b1;
                end
            end
            ncf_pkg::S_AQY: r_sq <= r_prod[63:0];
            ncf_pkg::S_AQZ: r_sq <= w_sqt;
            ncf_pkg::S_SQ_W: begin
                if (w_sqrt_done) begin
                    r_len <= w_root;
                end
            end
            ncf_pkg::S_LEN: begin
                r_j <= '0;
                if (r_len == '0) begin
                    r_f[0] <= '0;
                    r_f[1] <= '0;
                    r_f[2] <= '0;
                end
                // Unity gain without both limits; zero span saturates unless len is min.
                if (r_min == '0 || r_max == '0) begin
                    r_scale <= 32'sd1 <<< ncf_pkg::FRAC;
                end else if (w_num[32]) begin
                    r_scale <= 32'sh8000_0000;
                end else if (w_num != '0) begin
                    r_scale <= 32'sh7FFF_FFFF;
                end else begin
                    r_scale <= '0;
                end
            end
            ncf_pkg::S_SC_W: begin
                if (w_div_done) begin
                    if (w_num[32]) begin
                        r_scale <= (w_quo > ncf_pkg::DIV_W'(33'h0_8000_0000))
                                   ? 32'sh8000_0000 : -w_quo[31:0];
                    end else begin
                        r_scale <= (w_quo > ncf_pkg::DIV_W'(32'h7FFF_FFFF))
                                   ? 32'sh7FFF_FFFF : w_quo[31:0];
                    end
                end
            end
            ncf_pkg::S_U_W: begin
                if (w_div_done) begin
                    r_u <= r_avg[r_j][31] ? -w_quo[17:0] : w_quo[17:0];
                end
            end
            ncf_pkg::S_G_T: r_g <= w_ptr[32:0];
            ncf_pkg::S_F_T: begin
                r_f[r_j] <= f_sat32(w_ptr);
                r_j      <= r_j + 1'b1;
            end
            default: ;
        endcase
    end

    assign w_out_free = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.step == ncf_pkg::S_OUT && w_out_free) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step == ncf_pkg::S_OUT && w_out_free) begin
            r_o_id <= r_id;
            r_o_fx <= r_f[0];
            r_o_fy <= r_f[1];
            r_o_fz <= r_f[2];
        end
    end

    assign o_stat.active    = r_active;
    assign o_stat.n_zero    = (w_n_use == '0);
    assign o_stat.walk_last = (r_k == w_n_use - 1'b1);
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.div_done  = w_div_done;
    assign o_stat.sqrt_done = w_sqrt_done;
    assign o_stat.len_zero  = (r_len == '0);
    assign o_stat.scale_div = (r_min != '0) && (r_max != '0) && (r_min != r_max);
    assign o_stat.comp_last = (r_j == 2'd2);
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid = r_ov;
    assign o_part_id   = r_o_id;
    assign o_force_x   = r_o_fx;
    assign o_force_y   = r_o_fy;
    assign o_force_z   = r_o_fz;

endmodule

// ===== rtl/core/ncf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences the neighbor walk and the force steps.
module ncf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_op,
    input  ncf_pkg::t_stat i_stat,
    output ncf_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);

    ncf_pkg::t_state r_state;
    ncf_pkg::t_state n_state;
    logic            w_take;

    assign w_take = i_in_valid && (r_state == ncf_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ncf_pkg::S_IDLE: begin
                if (w_take && i_op == ncf_pkg::OP_QUERY && i_stat.active) begin
                    n_state = ncf_pkg::S_INIT;
                end
            end
            ncf_pkg::S_INIT: n_state = ncf_pkg::S_MX2;
            ncf_pkg::S_MX2:  n_state = ncf_pkg::S_LIM;
            ncf_pkg::S_LIM:  n_state = i_stat.n_zero ? ncf_pkg::S_CHK : ncf_pkg::S_RD;
            ncf_pkg::S_RD:   n_state = ncf_pkg::S_DIFF;
            ncf_pkg::S_DIFF: n_state = ncf_pkg::S_SQX;
            ncf_pkg::S_SQX:  n_state = ncf_pkg::S_SQY;
            ncf_pkg::S_SQY:  n_state = ncf_pkg::S_SQZ;
            ncf_pkg::S_SQZ:  n_state = ncf_pkg::S_ACC;
            ncf_pkg::S_ACC:  n_state = i_stat.walk_last ? ncf_pkg::S_CHK : ncf_pkg::S_RD;
            ncf_pkg::S_CHK:  n_state = i_stat.cnt_zero ? ncf_pkg::S_IDLE : ncf_pkg::S_AV_S;
            ncf_pkg::S_AV_S: n_state = ncf_pkg::S_AV_W;
            ncf_pkg::S_AV_W: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.comp_last ? ncf_pkg::S_AQX : ncf_pkg::S_AV_S;
                end
            end
            ncf_pkg::S_AQX:  n_state = ncf_pkg::S_AQY;
            ncf_pkg::S_AQY:  n_state = ncf_pkg::S_AQZ;
            ncf_pkg::S_AQZ:  n_state = ncf_pkg::S_AQS;
            ncf_pkg::S_AQS:  n_state = ncf_pkg::S_SQ_W;
            ncf_pkg::S_SQ_W: begin
                if (i_stat.sqrt_done) begin
                    n_state = ncf_pkg::S_LEN;
                end
            end
            ncf_pkg::S_LEN: begin
                if (i_stat.len_zero) begin
                    n_state = ncf_pkg::S_OUT;
                end else if (i_stat.scale_div) begin
                    n_state = ncf_pkg::S_SC_S;
                end else begin
                    n_state = ncf_pkg::S_U_S;
                end
            end
            ncf_pkg::S_SC_S: n_state = ncf_pkg::S_SC_W;
            ncf_pkg::S_SC_W: begin
                if (i_stat.div_done) begin
                    n_state = ncf_pkg::S_U_S;
                end
            end
            ncf_pkg::S_U_S:  n_state = ncf_pkg::S_U_W;
            ncf_pkg::S_U_W: begin
                if (i_stat.div_done) begin
                    n_state = ncf_pkg::S_G_M;
                end
            end
            ncf_pkg::S_G_M:  n_state = ncf_pkg::S_G_T;
            ncf_pkg::S_G_T:  n_state = ncf_pkg::S_F_M;
            ncf_pkg::S_F_M:  n_state = ncf_pkg::S_F_T;
            ncf_pkg::S_F_T:  n_state = i_stat.comp_last ? ncf_pkg::S_OUT : ncf_pkg::S_U_S;
            ncf_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ncf_pkg::S_IDLE;
                end
            end
            default: n_state = ncf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ncf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.step = r_state;
    assign o_cmd.take = w_take;
    assign o_in_stall = (r_state != ncf_pkg::S_IDLE);

endmodule

// ===== rtl/core/ncf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker of the cohesion force block and its bind to the top level.
`include "assert_macros.svh"

module ncf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               i_op,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [5:0]         o_part_id,
    input logic signed [31:0] o_force_x
);

    // A load never leaves the idle state, so the input stays open.
    `NCF_ASSERT_NEXT(a_load_keeps_open, i_in_valid && !o_in_stall && i_op == ncf_pkg::OP_LOAD, !o_in_stall)

    // A new result is only ever produced at the end of a query.
    `NCF_ASSERT_NOW(a_result_after_query, $rose(o_out_valid), $past(o_in_stall))

    `NCF_ASSERT_NEXT(a_valid_holds, o_out_valid && i_out_stall, o_out_valid)

    `NCF_ASSERT_NEXT(a_word_holds, o_out_valid && i_out_stall, $stable(o_part_id) && $stable(o_force_x))

endmodule

bind neighbor_cohesion_force ncf_checker u_ncf_checker (.*);
